// File: rtl/png_scanline_unfilter_assert.svh
// Assertion macros for the PNG scanline unfilter.
// Expects clk_i and rst_ni in the scope of the module that includes it.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psu_pkg.sv
// Package for the PNG scanline unfilter: default sizes, filter codes and
// configuration register indexes. No dependencies.
package psu_pkg;

  localparam int unsigned MAX_ROW_BYTES_DEF   = 8192;
  localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

  localparam int unsigned CFG_W     = 14;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned BPP_W     = 4;
  localparam int unsigned ROW_W     = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_ROW_BYTES       = 1'b1
  } cfg_idx_e;

  typedef enum logic [7:0] {
    FILT_NONE  = 8'd0,
    FILT_SUB   = 8'd1,
    FILT_UP    = 8'd2,
    FILT_AVG   = 8'd3,
    FILT_PAETH = 8'd4
  } filter_e;

endpackage

// File: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter top level: None/Sub/Up/Average/Paeth reconstruction.
// Depends on psu_pkg and png_scanline_unfilter_assert.svh.
//
// One byte is taken per cycle, back to back, unless the output stalls; it
// passes the accept stage and then the result register. The first byte of a
// row is the filter type and gives no result. The previous row sits in a
// MAX_ROW_BYTES-deep byte memory, read at accept and written when the byte is
// reconstructed; that single read and single write per cycle set the rate.
// The memory needs no clearing after reset; an image's first row ignores it.
module png_scanline_unfilter #(
  parameter int unsigned MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES_DEF,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psu_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  input  logic                          s_axis_tuser,  // [0] image_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] pixel_byte
  output logic                          m_axis_tlast   // row_last
);

  `include "png_scanline_unfilter_assert.svh"

  localparam int unsigned POS_W = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned AW    = $clog2(MAX_ROW_BYTES);
  localparam int unsigned PIX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [psu_pkg::BPP_W-1:0] bpp_q;
  logic [psu_pkg::ROW_W-1:0] row_q;

  logic [POS_W-1:0] rp_q, rp_d;
  logic             first_q, first_d;
  logic [7:0]       filt_q, filt_d;

  logic             s1_valid_q;
  logic             s1_data_q;
  logic [7:0]       s1_x_q;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_last_q;
  logic [7:0]       s1_filt_q;
  logic             s1_first_q;
  logic             s1_aok_q;
  logic [PIX_W-1:0] s1_bidx_q;
  logic [7:0]       rdata_q;

  logic [7:0] left_q [MAX_PIXEL_BYTES];
  logic [7:0] ul_q   [MAX_PIXEL_BYTES];
  logic [7:0] prior_mem [MAX_ROW_BYTES];

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_last_q;

  logic                      acc, s1_adv, s1_wr;
  logic [POS_W-1:0]          rp_eff, pos, rb_eff;
  logic                      first_eff, acc_data, acc_last, acc_aok;
  logic [psu_pkg::BPP_W-1:0] bpp_eff;
  logic [AW-1:0]             acc_addr;
  logic [7:0]                a, b, c, pred, recon;
  logic signed [9:0]         pa, pb, pc;

  function automatic logic signed [9:0] abs10(input logic signed [9:0] v);
    return v[9] ? -v : v;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= psu_pkg::BPP_W'(1);
      row_q <= psu_pkg::ROW_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psu_pkg::CFG_BYTES_PER_PIXEL: bpp_q <= cfg_wdata_i[psu_pkg::BPP_W-1:0];
        psu_pkg::CFG_ROW_BYTES:       row_q <= cfg_wdata_i[psu_pkg::ROW_W-1:0];
        default:                      bpp_q <= bpp_q;
      endcase
    end
  end

  // accept stage
  assign s1_adv        = s1_valid_q && (!s1_data_q || !out_valid_q || m_axis_tready);
  assign s1_wr         = s1_adv && s1_data_q;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = psu_pkg::BPP_W'(1);
    end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
      bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = bpp_q;
    end
    if (row_q == '0) begin
      rb_eff = POS_W'(1);
    end else if (32'(row_q) > MAX_ROW_BYTES) begin
      rb_eff = POS_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = POS_W'(row_q);
    end
    rp_eff    = s_axis_tuser ? '0 : rp_q;
    first_eff = s_axis_tuser || first_q;
    acc_data  = (rp_eff != '0);
    pos       = rp_eff - POS_W'(1);
    if (32'(pos) >= MAX_ROW_BYTES) begin
      pos = POS_W'(MAX_ROW_BYTES - 1);
    end
    acc_addr = AW'(pos);
    acc_aok  = (pos >= POS_W'(bpp_eff));
    acc_last = (rp_eff >= rb_eff);
    rp_d     = rp_q;
    first_d  = first_q;
    filt_d   = filt_q;
    if (acc) begin
      first_d = first_eff;
      if (!acc_data) begin
        filt_d = s_axis_tdata;
        rp_d   = POS_W'(1);
      end else if (acc_last) begin
        rp_d    = '0;
        first_d = 1'b0;
      end else begin
        rp_d = rp_eff + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q       <= '0;
      first_q    <= 1'b1;
      filt_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      rp_q    <= rp_d;
      first_q <= first_d;
      filt_q  <= filt_d;
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_data_q  <= acc_data;
      s1_x_q     <= s_axis_tdata;
      s1_addr_q  <= acc_addr;
      s1_last_q  <= acc_last;
      s1_filt_q  <= filt_q;
      s1_first_q <= first_eff;
      s1_aok_q   <= acc_aok;
      s1_bidx_q  <= PIX_W'(bpp_eff - psu_pkg::BPP_W'(1));
    end
  end

  // previous row
  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      prior_mem[s1_addr_q] <= recon;
    end
    if (acc) begin
      rdata_q <= prior_mem[acc_addr];
    end
  end

  // reconstruction
  always_comb begin
    a  = s1_aok_q ? left_q[s1_bidx_q] : 8'd0;
    b  = s1_first_q ? 8'd0 : rdata_q;
    c  = (!s1_first_q && s1_aok_q) ? ul_q[s1_bidx_q] : 8'd0;
    pa = abs10(10'(b) - 10'(c));
    pb = abs10(10'(a) - 10'(c));
    pc = abs10(10'(a) + 10'(b) - 10'(c) - 10'(c));
    case (s1_filt_q)
      psu_pkg::FILT_SUB: pred = a;
      psu_pkg::FILT_UP:  pred = b;
      psu_pkg::FILT_AVG: pred = 8'((9'(a) + 9'(b)) >> 1);
      psu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = 8'd0;
    endcase
    recon = s1_x_q + pred;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_q[k] <= '0;
        ul_q[k]   <= '0;
      end
    end else if (s1_adv) begin
      if (s1_data_q) begin
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
          left_q[k] <= left_q[k-1];
          ul_q[k]   <= ul_q[k-1];
        end
        left_q[0] <= recon;
        ul_q[0]   <= b;
      end else begin
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          left_q[k] <= '0;
          ul_q[k]   <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_wr) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      out_data_q <= recon;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `PSU_ASSERT_IMP(a_ready_when_empty, !s1_valid_q, s_axis_tready, "stage empty but not ready")
  `PSU_ASSERT_IMP(a_no_rw_clash, s1_wr && acc && acc_data, s1_addr_q != acc_addr,
                  "row memory read and write at one address")
  `PSU_ASSERT_NXT(a_result_loaded, s1_wr, m_axis_tvalid, "reconstructed byte lost")
  `PSU_ASSERT_NXT(a_row_end_rewinds, acc && acc_data && acc_last, rp_q == '0,
                  "row end did not rewind position")

endmodule
